@@ rtl/qtic_pkg.sv @@
package qtic_pkg;

   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_START_POSITION = 2'd0,
      CSR_END_POSITION   = 2'd1,
      CSR_MOVE_DURATION  = 2'd2
   } csr_index_type;

endpackage

@@ rtl/quintic_trajectory_interpolator_core.sv @@
// throughput: one item per cycle while req_tready is high; the divider has one register
// stage per quotient bit, and the blend polynomial and scaling run in registered stages
// a one-entry skid buffer behind the output register keeps req_tready registered
// reset (synchronous, active high) empties the pipeline and clears all three
// configuration registers to zero
module quintic_trajectory_interpolator_core
   import qtic_pkg::*;
#(
   parameter int POSITION_WIDTH = 32,
   parameter int TIME_WIDTH     = 32,
   parameter int FRACTION_BITS  = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // elapsed_time
   input  logic [((TIME_WIDTH+7)/8)*8-1:0]              req_tdata,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // position
   output logic [((POSITION_WIDTH+7)/8)*8-1:0]          rsp_tdata,
   // move_done
   output logic                                         rsp_tuser,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]                   csr_index,
   input  logic [((POSITION_WIDTH > TIME_WIDTH) ? POSITION_WIDTH : TIME_WIDTH)-1:0] csr_data
);

   localparam int PW = POSITION_WIDTH;
   localparam int TW = TIME_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int RSP_DATA_WIDTH = ((POSITION_WIDTH + 7) / 8) * 8;
   localparam int DEPTH = F + 7;
   localparam int LAST  = DEPTH - 1;

   localparam logic [2*F:0]   HALF_SQ   = (2*F+1)'(1) << (F - 1);
   localparam logic [2*F+4:0] HALF_BL   = (2*F+5)'(1) << (F - 1);
   localparam logic [PW+F+2:0] HALF_SC  = (PW+F+3)'(1) << (F - 1);
   localparam logic [F+3:0]   TEN_Q     = (F+4)'(10) << F;
   localparam logic [F+4:0]   ONE_Q     = (F+5)'(1) << F;
   localparam logic [PW-1:0]  POS_MAX   = {1'b0, {(PW-1){1'b1}}};
   localparam logic [PW-1:0]  POS_MIN   = {1'b1, {(PW-1){1'b0}}};

   // configuration
   logic [PW-1:0] start_ff;
   logic [PW-1:0] end_ff;
   logic [TW-1:0] dur_ff;
   logic [PW:0]   mag_ff;
   logic          neg_ff;
   logic [PW:0]   delta;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
         dur_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_POSITION: start_ff <= csr_data[PW-1:0];
            CSR_END_POSITION:   end_ff   <= csr_data[PW-1:0];
            CSR_MOVE_DURATION:  dur_ff   <= csr_data[TW-1:0];
            default: ;
         endcase
      end
   end

   assign delta = {end_ff[PW-1], end_ff} - {start_ff[PW-1], start_ff};

   always_ff @(posedge clock) begin
      neg_ff <= delta[PW];
      mag_ff <= delta[PW] ? (~delta + (PW+1)'(1)) : delta;
   end

   // pipeline control
   logic en;
   logic valid_ff [0:LAST];
   logic done_ff  [0:LAST];
   logic sk_valid_ff;

   assign en         = !sk_valid_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req_tvalid;
         for (int i = 1; i < DEPTH; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         done_ff[0] <= req_tdata[TW-1:0] >= dur_ff;
         for (int i = 1; i < DEPTH; i++) done_ff[i] <= done_ff[i-1];
      end
   end

   // restoring divider, one quotient bit per stage
   logic [TW-1:0] rem_ff [0:F];
   logic [F-1:0]  q_ff   [0:F];
   logic [TW:0]   rem_sh [1:F];
   logic          ge     [1:F];
   logic [TW:0]   rem_in [1:F];

   always_comb begin
      for (int i = 1; i <= F; i++) begin
         rem_sh[i] = {rem_ff[i-1], 1'b0};
         ge[i]     = rem_sh[i] >= {1'b0, dur_ff};
         rem_in[i] = ge[i] ? (rem_sh[i] - {1'b0, dur_ff}) : rem_sh[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= req_tdata[TW-1:0];
         q_ff[0]   <= '0;
         for (int i = 1; i <= F; i++) begin
            rem_ff[i] <= rem_in[i][TW-1:0];
            q_ff[i]   <= {q_ff[i-1][F-2:0], ge[i]};
         end
      end
   end

   // blend polynomial
   logic [2*F-1:0] sq_ff;
   logic [F-1:0]   u1_ff;
   logic [2*F-1:0] cube_ff;
   logic [F-1:0]   u2_ff;
   logic [F-1:0]   u2u_ff;
   logic [F-1:0]   u3_ff;
   logic [F+3:0]   poly_ff;
   logic [2*F+3:0] blprod_ff;
   logic [F:0]     bl_ff;
   logic [PW+F+1:0] scaled_ff;

   logic [2*F:0]   sq_rnd;
   logic [2*F:0]   cube_rnd;
   logic [F+3:0]   poly_a;
   logic [F+3:0]   poly_b;
   logic [2*F+4:0] bl_rnd;
   logic [F+4:0]   bl_full;

   assign sq_rnd   = {1'b0, sq_ff} + HALF_SQ;
   assign cube_rnd = {1'b0, cube_ff} + HALF_SQ;
   assign poly_a   = TEN_Q + ((F+4)'(u2_ff) * (F+4)'(6));
   assign poly_b   = (F+4)'(u2u_ff) * (F+4)'(15);
   assign bl_rnd   = {1'b0, blprod_ff} + HALF_BL;
   assign bl_full  = bl_rnd[2*F+4:F];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff     <= q_ff[F] * q_ff[F];
         u1_ff     <= q_ff[F];
         cube_ff   <= sq_rnd[2*F-1:F] * u1_ff;
         u2_ff     <= sq_rnd[2*F-1:F];
         u2u_ff    <= u1_ff;
         u3_ff     <= cube_rnd[2*F-1:F];
         poly_ff   <= (poly_a > poly_b) ? (poly_a - poly_b) : '0;
         blprod_ff <= u3_ff * poly_ff;
         bl_ff     <= (bl_full > ONE_Q) ? ONE_Q[F:0] : bl_full[F:0];
         scaled_ff <= mag_ff * bl_ff;
      end
   end

   // rounding, sign and saturation
   logic [PW+F+2:0] sc_rnd;
   logic [PW:0]     step;
   logic [PW+2:0]   sum;
   logic [PW-1:0]   pos_sat;
   logic [PW-1:0]   pos_fin;

   assign sc_rnd = {1'b0, scaled_ff} + HALF_SC;
   assign step   = sc_rnd[PW+F:F];
   assign sum    = neg_ff ? ({{3{start_ff[PW-1]}}, start_ff} - {2'b0, step})
                          : ({{3{start_ff[PW-1]}}, start_ff} + {2'b0, step});

   always_comb begin
      if (sum[PW+2:PW-1] == '0 || sum[PW+2:PW-1] == '1) begin
         pos_sat = sum[PW-1:0];
      end else if (sum[PW+2]) begin
         pos_sat = POS_MIN;
      end else begin
         pos_sat = POS_MAX;
      end
      pos_fin = done_ff[LAST] ? end_ff : pos_sat;
   end

   // output register and skid buffer
   logic          ob_valid_ff;
   logic [PW-1:0] ob_pos_ff;
   logic          ob_done_ff;
   logic [PW-1:0] sk_pos_ff;
   logic          sk_done_ff;
   logic          inc_valid;

   assign inc_valid = en && valid_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_valid_ff <= 1'b0;
         sk_valid_ff <= 1'b0;
      end else if (!ob_valid_ff || rsp_tready) begin
         if (sk_valid_ff) begin
            ob_valid_ff <= 1'b1;
            sk_valid_ff <= 1'b0;
         end else begin
            ob_valid_ff <= inc_valid;
         end
      end else if (inc_valid) begin
         sk_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!ob_valid_ff || rsp_tready) begin
         if (sk_valid_ff) begin
            ob_pos_ff  <= sk_pos_ff;
            ob_done_ff <= sk_done_ff;
         end else begin
            ob_pos_ff  <= pos_fin;
            ob_done_ff <= done_ff[LAST];
         end
      end else if (inc_valid) begin
         sk_pos_ff  <= pos_fin;
         sk_done_ff <= done_ff[LAST];
      end
   end

   assign rsp_tvalid = ob_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'(ob_pos_ff);
   assign rsp_tuser  = ob_done_ff;

endmodule

@@ rtl/qtic_checker.sv @@
module qtic_checker
   import qtic_pkg::*;
#(
   parameter int POSITION_WIDTH = 32,
   parameter int TIME_WIDTH     = 32,
   parameter int FRACTION_BITS  = 16
) (
   input logic                                         clock,
   input logic                                         reset,
   input logic [((TIME_WIDTH+7)/8)*8-1:0]              req_tdata,
   input logic                                         req_tvalid,
   input logic                                         req_tready,
   input logic [((POSITION_WIDTH+7)/8)*8-1:0]          rsp_tdata,
   input logic                                         rsp_tuser,
   input logic                                         rsp_tvalid,
   input logic                                         rsp_tready,
   input logic                                         csr_valid,
   input logic                                         csr_ready,
   input logic [CSR_INDEX_WIDTH-1:0]                   csr_index,
   input logic [((POSITION_WIDTH > TIME_WIDTH) ? POSITION_WIDTH : TIME_WIDTH)-1:0] csr_data
);

   logic [POSITION_WIDTH-1:0] end_ff;
   logic [TIME_WIDTH-1:0]     dur_ff;
   logic                      unused_ok;

   assign unused_ok = ^{req_tdata, req_tvalid, FRACTION_BITS};

   always_ff @(posedge clock) begin
      if (reset) begin
         end_ff <= '0;
         dur_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_END_POSITION) end_ff <= csr_data[POSITION_WIDTH-1:0];
         if (csr_index == CSR_MOVE_DURATION) dur_ff <= csr_data[TIME_WIDTH-1:0];
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_done_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[POSITION_WIDTH-1:0] == end_ff)
      else $error("finished move does not sit at end position");

   a_zero_dur: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && dur_ff == '0 |-> rsp_tuser)
      else $error("zero duration move not flagged done");

   a_skid: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && unused_ok == unused_ok)
      else $error("input stalled with no rsp item pending");

endmodule

bind quintic_trajectory_interpolator_core qtic_checker #(
   .POSITION_WIDTH(POSITION_WIDTH),
   .TIME_WIDTH(TIME_WIDTH),
   .FRACTION_BITS(FRACTION_BITS)
) u_qtic_checker (.*);
